// ----- rtl/core/marker_crc16_frame_receiver_defines.svh -----
// Assertion macros shared by the frame receiver RTL.
`ifndef MARKER_CRC16_FRAME_RECEIVER_DEFINES_SVH
`define MARKER_CRC16_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MCRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mcrc_pkg.sv -----
// Shared types, constants and the CRC byte update for the frame receiver.
package mcrc_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BADCRC   = 2'd3
  } status_t;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic [7:0]  MARK_FIRST  = 8'hAA;
  localparam logic [7:0]  MARK_SECOND = 8'h55;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] MS_MAX      = 16'hFFFF;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [15:0] CAPACITY_RESET = 16'd4096;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    status_t     status;
    logic [7:0]  func_code;
    logic [15:0] payload_len;
  } result_t;

  // Reflected CRC-16 update for one byte, LSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/mcrc_deframer.sv -----
// Frame state machine: marker hunt, header, payload, CRC check and timing.
`include "marker_crc16_frame_receiver_defines.svh"

module mcrc_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              cmd,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       timeout_ms,
  input  logic [15:0]       payload_capacity,
  output logic              res_valid,
  output mcrc_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CODE    = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_CRC_LO  = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  prev_byte, prev_byte_next;
  logic [7:0]  frame_code, frame_code_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_taken, bytes_taken_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_hi, crc_hi_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [15:0] byte_limit, byte_limit_next;

  logic                  finish;
  mcrc_pkg::status_t     fin_status;
  logic [15:0]           elapsed_inc;
  logic [15:0]           time_left;
  logic [15:0]           crc_upd;
  logic [15:0]           len_full;
  logic [15:0]           taken_inc;

  assign elapsed_inc = (elapsed_ms == mcrc_pkg::MS_MAX) ? elapsed_ms : elapsed_ms + 16'd1;
  assign time_left   = timeout_ms - elapsed_ms;
  assign crc_upd     = mcrc_pkg::crc_fold(running_crc, rx_byte);
  assign len_full    = {frame_length[15:8], rx_byte};
  assign taken_inc   = bytes_taken + 16'd1;

  always_comb begin
    phase_next        = phase;
    prev_byte_next    = prev_byte;
    frame_code_next   = frame_code;
    frame_length_next = frame_length;
    bytes_taken_next  = bytes_taken;
    running_crc_next  = running_crc;
    crc_hi_next       = crc_hi;
    elapsed_ms_next   = elapsed_ms;
    byte_limit_next   = byte_limit;
    finish            = 1'b0;
    fin_status        = mcrc_pkg::ST_OK;
    res_valid         = 1'b0;
    res               = '0;

    if (cmd == mcrc_pkg::CMD_TICK) begin
      elapsed_ms_next = elapsed_inc;
      if (phase == PH_HUNT) begin
        if (elapsed_inc >= timeout_ms) begin
          finish     = 1'b1;
          fin_status = mcrc_pkg::ST_TIMEOUT;
        end
      end else if (elapsed_inc >= byte_limit) begin
        finish     = 1'b1;
        fin_status = mcrc_pkg::ST_TIMEOUT;
      end
    end else if (phase == PH_HUNT) begin
      if (elapsed_ms >= timeout_ms) begin
        // deadline already passed: the byte is dropped
        finish     = 1'b1;
        fin_status = mcrc_pkg::ST_TIMEOUT;
      end else if (prev_byte == mcrc_pkg::MARK_FIRST && rx_byte == mcrc_pkg::MARK_SECOND) begin
        byte_limit_next  = (time_left != 16'd0) ? time_left : 16'd1;
        elapsed_ms_next  = '0;
        running_crc_next = mcrc_pkg::CRC_INIT;
        phase_next       = PH_CODE;
      end else begin
        prev_byte_next = rx_byte;
      end
    end else begin
      elapsed_ms_next = '0;
      unique case (phase)
        PH_CODE: begin
          frame_code_next  = rx_byte;
          running_crc_next = crc_upd;
          phase_next       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_length_next = {rx_byte, 8'h00};
          running_crc_next  = crc_upd;
          phase_next        = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_length_next = len_full;
          running_crc_next  = crc_upd;
          if (len_full > payload_capacity) begin
            finish     = 1'b1;
            fin_status = mcrc_pkg::ST_OVERFLOW;
          end else begin
            bytes_taken_next = '0;
            phase_next       = (len_full == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_upd;
          bytes_taken_next = taken_inc;
          if (taken_inc >= frame_length) begin
            phase_next = PH_CRC_HI;
          end
          res_valid      = 1'b1;
          res.kind       = mcrc_pkg::KIND_BYTE;
          res.data_byte  = rx_byte;
          res.byte_index = bytes_taken;
        end
        PH_CRC_HI: begin
          crc_hi_next = rx_byte;
          phase_next  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          finish     = 1'b1;
          fin_status = ({crc_hi, rx_byte} != running_crc) ? mcrc_pkg::ST_BADCRC
                                                          : mcrc_pkg::ST_OK;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end

    if (finish) begin
      res_valid   = 1'b1;
      res         = '0;
      res.kind    = mcrc_pkg::KIND_STATUS;
      res.status  = fin_status;
      if (fin_status == mcrc_pkg::ST_OK) begin
        res.func_code   = frame_code;
        res.payload_len = frame_length;
      end
      phase_next        = PH_HUNT;
      prev_byte_next    = '0;
      frame_code_next   = '0;
      frame_length_next = '0;
      bytes_taken_next  = '0;
      running_crc_next  = mcrc_pkg::CRC_INIT;
      crc_hi_next       = '0;
      elapsed_ms_next   = '0;
      byte_limit_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      prev_byte    <= '0;
      frame_code   <= '0;
      frame_length <= '0;
      bytes_taken  <= '0;
      running_crc  <= mcrc_pkg::CRC_INIT;
      crc_hi       <= '0;
      elapsed_ms   <= '0;
      byte_limit   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      prev_byte    <= prev_byte_next;
      frame_code   <= frame_code_next;
      frame_length <= frame_length_next;
      bytes_taken  <= bytes_taken_next;
      running_crc  <= running_crc_next;
      crc_hi       <= crc_hi_next;
      elapsed_ms   <= elapsed_ms_next;
      byte_limit   <= byte_limit_next;
    end
  end

  `MCRC_ASSERT_NOW(a_byte_only_in_payload, res_valid && res.kind == mcrc_pkg::KIND_BYTE, phase == PH_PAYLOAD, "payload beat outside payload phase")
  `MCRC_ASSERT_NEXT(a_status_rearms, step && res_valid && res.kind == mcrc_pkg::KIND_STATUS, phase == PH_HUNT && running_crc == mcrc_pkg::CRC_INIT && elapsed_ms == 16'd0, "status did not re-arm")
  `MCRC_ASSERT_NOW(a_index_in_range, phase == PH_PAYLOAD, bytes_taken < frame_length, "payload index past length")
  `MCRC_ASSERT_NOW(a_limit_nonzero, phase != PH_HUNT, byte_limit != 16'd0, "byte deadline zero after sync")

endmodule

// ----- rtl/core/marker_crc16_frame_receiver.sv -----
// Marker-synchronized CRC-16 frame receiver: top level with config and beat registers.
//
// Input stream (s_*): one beat per received byte (tuser 0, byte in tdata) or per
// millisecond tick (tuser 1). The block hunts for 0xAA 0x55, reads code, length,
// payload and CRC, and forwards each payload byte as an output beat (tuser 0).
// Every frame ends with one status beat (tuser 1): ok, timeout, overflow, bad CRC.
// Ticks and most bytes produce no output beat.
// Config: cfg_we writes cfg_data into register cfg_index (0 timeout_ms,
// 1 payload_capacity); write only while the block is idle.
// An accepted input beat is held in the input register until it steps the state
// machine; its output beat, if any, is loaded into the output register at that step.
// Throughput: one input beat per cycle while the output is not stalled; the combinational
// CRC byte update and the state step sit between the input register and the output register.
// Stall: while m_tready is low a waiting output holds, one more beat may be
// taken into the input register, then s_tready drops.
// Reset: rst (synchronous) empties both registers, returns to marker hunt and
// loads the default timeout (1000 ms) and capacity (4096).
module marker_crc16_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] data_byte, [23:8] byte_index, [25:24] status,
                                 // [33:26] func_code, [49:34] payload_len, [55:50] zero
  output logic        m_tuser,   // [0] result_kind
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] timeout_ms;
  logic [15:0] payload_capacity;

  logic        in_valid;
  logic        in_cmd;
  logic [7:0]  in_byte;
  logic        proc_en;

  logic              res_valid;
  mcrc_pkg::result_t res;
  mcrc_pkg::result_t out_res;

  assign proc_en  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || proc_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms       <= mcrc_pkg::TIMEOUT_RESET;
      payload_capacity <= mcrc_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcrc_pkg::REG_TIMEOUT:  timeout_ms       <= cfg_data;
        mcrc_pkg::REG_CAPACITY: payload_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  mcrc_deframer u_deframer (
    .clk              (clk),
    .rst              (rst),
    .step             (proc_en),
    .cmd              (in_cmd),
    .rx_byte          (in_byte),
    .timeout_ms       (timeout_ms),
    .payload_capacity (payload_capacity),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc_en) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {6'b0, out_res.payload_len, out_res.func_code, out_res.status,
                    out_res.byte_index, out_res.data_byte};

endmodule
